// ===== design/ssbg_pkg.sv =====
// Shared types and constants for the swept square beep generator.
package ssbg_pkg;

  localparam int PHASE_W = 7;
  localparam int ELAPSED_W = 20;
  localparam int ACC_W = 32;
  localparam int STEP_W = 16;
  localparam int EDGE_W = 16;
  localparam int AMP_W = 10;
  localparam int DAC_W = 12;
  localparam int DIV_CNT_W = 5;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [DAC_W-1:0] MID_CODE = 12'd2048;
  localparam logic [13:0] AMP_MAX = 14'd700;
  localparam logic [13:0] AMP_MIN = 14'd50;
  localparam logic [13:0] VOL_SCALE = 14'd10;
  localparam logic [ELAPSED_W-1:0] TICKS_PER_MS = 20'd10;
  localparam logic [ACC_W-1:0] HALF_PERIOD_NUM = 32'd327680000;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/ssbg_ctrl.sv =====
// Sequencer: accept, divide on start, apply state update, present result.
module ssbg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  ssbg_pkg::status_t status,
  output ssbg_pkg::cmd_t    cmd
);
  import ssbg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (command == CMD_START) ? S_DIV : S_APPLY;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/ssbg_datapath.sv =====
// Beep state, serial half-period divider and output beat register.
module ssbg_datapath #(
  parameter int WARMUP_END = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ssbg_pkg::cmd_t                  cmd,
  output ssbg_pkg::status_t               status,
  input  logic                            command,
  input  logic [15:0]                     length_ms,
  input  logic [15:0]                     start_hz,
  input  logic signed [15:0]              sweep_step,
  input  logic [9:0]                      volume_pct,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ssbg_pkg::DAC_W-1:0]      dac_code,
  output logic                            amp_enable,
  output logic                            busy_res
);
  import ssbg_pkg::*;

  localparam logic [PHASE_W-1:0] WARM_END = PHASE_W'(WARMUP_END);

  // latched beat
  logic                 cmd_q;
  logic [15:0]          len_q;
  logic [15:0]          step_in_q;
  logic [9:0]           vol_q;

  // divider
  logic [15:0]          divisor;
  logic [15:0]          rem;
  logic [ACC_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [16:0]          rem_shift;
  logic                 q_bit;

  // beep state
  logic [PHASE_W-1:0]   phase_count;
  logic [ELAPSED_W-1:0] elapsed_ticks;
  logic [ELAPSED_W-1:0] duration_ticks;
  logic signed [ACC_W-1:0] half_period_acc;
  logic signed [STEP_W-1:0] period_step;
  logic [EDGE_W-1:0]    edge_count;
  logic                 wave_polarity;
  logic [AMP_W-1:0]     amplitude;
  logic [DAC_W-1:0]     dac_level;
  logic                 amp_on;

  logic [13:0]          vol_scaled;
  logic [AMP_W-1:0]     amp_clamped;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [EDGE_W-1:0]    edge_inc;
  logic [EDGE_W-1:0]    interval;
  logic signed [ACC_W:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat;

  assign rem_shift = {rem, quo[ACC_W-1]};
  assign q_bit = (rem_shift >= {1'b0, divisor});

  always_comb begin
    vol_scaled = 14'(vol_q) * VOL_SCALE;
    if (vol_scaled > AMP_MAX) begin
      amp_clamped = AMP_W'(AMP_MAX);
    end else if (vol_scaled < AMP_MIN) begin
      amp_clamped = AMP_W'(AMP_MIN);
    end else begin
      amp_clamped = vol_scaled[AMP_W-1:0];
    end
  end

  assign elapsed_inc = elapsed_ticks + 1'b1;
  assign edge_inc = edge_count + 1'b1;

  // toggle interval is the integer half-period, at least one tick
  always_comb begin
    if (half_period_acc[ACC_W-1] || half_period_acc[ACC_W-2:16] == '0) begin
      interval = EDGE_W'(1);
    end else begin
      interval = {1'b0, half_period_acc[ACC_W-2:16]};
    end
  end

  always_comb begin
    acc_sum = (ACC_W+1)'(half_period_acc) + (ACC_W+1)'(period_step);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  assign status.div_last = (div_cnt == '1);
  assign status.out_free = !out_valid || out_ready;

  // latch and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      len_q <= length_ms;
      step_in_q <= sweep_step;
      vol_q <= volume_pct;
      divisor <= (start_hz == '0) ? 16'd1 : start_hz;
      rem <= '0;
      quo <= HALF_PERIOD_NUM;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= q_bit ? 16'(rem_shift - {1'b0, divisor}) : rem_shift[15:0];
      quo <= {quo[ACC_W-2:0], q_bit};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      elapsed_ticks <= '0;
      duration_ticks <= '0;
      half_period_acc <= '0;
      period_step <= '0;
      edge_count <= '0;
      wave_polarity <= 1'b0;
      amplitude <= '0;
      dac_level <= MID_CODE;
      amp_on <= 1'b0;
    end else if (cmd.apply) begin
      if (cmd_q == CMD_START) begin
        amplitude <= amp_clamped;
        half_period_acc <= quo;
        duration_ticks <= ELAPSED_W'(len_q) * TICKS_PER_MS;
        period_step <= step_in_q;
        elapsed_ticks <= '0;
        phase_count <= PHASE_W'(1);
      end else if (phase_count == PHASE_W'(1)) begin
        amp_on <= 1'b1;
        edge_count <= '0;
        wave_polarity <= 1'b0;
        dac_level <= MID_CODE;
        phase_count <= PHASE_W'(2);
      end else if (phase_count > PHASE_W'(1) && phase_count < WARM_END) begin
        phase_count <= phase_count + 1'b1;
      end else if (phase_count == WARM_END) begin
        elapsed_ticks <= elapsed_inc;
        if (elapsed_inc >= duration_ticks) begin
          amp_on <= 1'b0;
          phase_count <= '0;
        end else begin
          if (edge_inc >= interval) begin
            dac_level <= wave_polarity ? (MID_CODE + DAC_W'(amplitude))
                                       : (MID_CODE - DAC_W'(amplitude));
            wave_polarity <= !wave_polarity;
            edge_count <= '0;
          end else begin
            edge_count <= edge_inc;
          end
          half_period_acc <= acc_sat;
        end
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dac_code <= dac_level;
      amp_enable <= amp_on;
      busy_res <= (phase_count != '0);
    end
  end

endmodule

// ===== design/swept_square_beep_generator.sv =====
// Top level of the swept square-wave beep generator.
//
//   channel | direction | handshake          | payload
//   in      | in        | in_valid/in_ready  | command, length_ms, start_hz, sweep_step, volume_pct
//   out     | out       | out_valid/out_ready| dac_code, amp_enable, busy_res
//
// A tick beat goes from acceptance to the state update and then to the output; a start
// beat first runs a restoring divider, one quotient bit a cycle, for the half-period.
// One beat is in work at a time; a new beat is taken while the last result
// still waits in the output register, and the block stalls only before
// presenting a result while that register is still held.
// Synchronous reset puts the beep idle, the DAC at midscale, amp off.
module swept_square_beep_generator #(
  parameter int WARMUP_END = 100
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [15:0]                length_ms,
  input  logic [15:0]                start_hz,
  input  logic signed [15:0]         sweep_step,
  input  logic [9:0]                 volume_pct,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ssbg_pkg::DAC_W-1:0] dac_code,
  output logic                       amp_enable,
  output logic                       busy_res
);
  import ssbg_pkg::*;

  cmd_t    cmd;
  status_t status;

  ssbg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  ssbg_datapath #(
    .WARMUP_END (WARMUP_END)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (command),
    .length_ms  (length_ms),
    .start_hz   (start_hz),
    .sweep_step (sweep_step),
    .volume_pct (volume_pct),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dac_code   (dac_code),
    .amp_enable (amp_enable),
    .busy_res   (busy_res)
  );

endmodule

// ===== sim/testbench.sv =====
// Testbench for the swept square beep generator: predicted results checked beat by beat.
module testbench;
  import ssbg_pkg::*;

  localparam int WARMUP_TICKS = 100;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_BEATS = 1000;

  typedef struct {
    logic [DAC_W-1:0] dac;
    logic             amp;
    logic             busy;
  } beep_out_t;

  // Tracks the beep state and holds the DAC/amp/busy results still to come.
  class beep_scoreboard;
    int               phase;
    logic [19:0]      elapsed;
    logic [19:0]      duration;
    int               acc;
    int               step;
    logic [15:0]      edge_cnt;
    logic             polarity;
    int               amp_lvl;
    logic [DAC_W-1:0] dac;
    logic             amp_on;
    beep_out_t        expq[$];
    int               errors;
    int               checked;
    int               sat_hi;
    int               sat_lo;

    function void reset_state();
      phase = 0;
      elapsed = '0;
      duration = '0;
      acc = 0;
      step = 0;
      edge_cnt = '0;
      polarity = 1'b0;
      amp_lvl = 0;
      dac = MID_CODE;
      amp_on = 1'b0;
      expq.delete();
      errors = 0;
      checked = 0;
      sat_hi = 0;
      sat_lo = 0;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function void note_beat(logic cmd, logic [15:0] len, logic [15:0] hz,
                            logic signed [15:0] sw, logic [9:0] vol);
      int        vol10;
      int        ival;
      longint    sum;
      logic [31:0] hz_eff;
      beep_out_t e;
      if (cmd == CMD_START) begin
        vol10 = int'(vol) * 10;
        if (vol10 > 700) vol10 = 700;
        else if (vol10 < 50) vol10 = 50;
        hz_eff = (hz == 16'd0) ? 32'd1 : {16'd0, hz};
        amp_lvl = vol10;
        acc = int'(HALF_PERIOD_NUM / hz_eff);
        duration = 20'(int'(len) * 10);
        step = int'(sw);
        elapsed = '0;
        phase = 1;
      end else if (phase == 1) begin
        amp_on = 1'b1;
        edge_cnt = '0;
        polarity = 1'b0;
        dac = MID_CODE;
        phase = 2;
      end else if (phase > 1 && phase < WARMUP_TICKS) begin
        phase++;
      end else if (phase == WARMUP_TICKS) begin
        elapsed = elapsed + 20'd1;
        if (elapsed >= duration) begin
          amp_on = 1'b0;
          phase = 0;
        end else begin
          ival = (acc < 65536) ? 1 : (acc >>> 16);
          edge_cnt = edge_cnt + 16'd1;
          if (int'({16'd0, edge_cnt}) >= ival) begin
            if (!polarity) begin
              dac = 12'(2048 - amp_lvl);
              polarity = 1'b1;
            end else begin
              dac = 12'(2048 + amp_lvl);
              polarity = 1'b0;
            end
            edge_cnt = '0;
          end
          sum = longint'(acc) + longint'(step);
          if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            sat_hi++;
          end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            sat_lo++;
          end
          acc = int'(sum);
        end
      end
      e.dac = dac;
      e.amp = amp_on;
      e.busy = (phase != 0);
      expq.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [DAC_W-1:0] got_dac, logic got_amp, logic got_busy);
      beep_out_t e;
      if (expq.size() == 0) begin
        report($sformatf("result with no beat waiting: dac %0d", got_dac));
      end else begin
        e = expq.pop_front();
        if (got_dac !== e.dac)
          report($sformatf("result %0d dac_code got %0d want %0d", checked, got_dac, e.dac));
        if (got_amp !== e.amp)
          report($sformatf("result %0d amp_enable got %b want %b", checked, got_amp, e.amp));
        if (got_busy !== e.busy)
          report($sformatf("result %0d busy_res got %b want %b", checked, got_busy, e.busy));
        checked++;
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = CMD_TICK;
  logic [15:0]        length_ms = '0;
  logic [15:0]        start_hz = '0;
  logic signed [15:0] sweep_step = '0;
  logic [9:0]         volume_pct = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DAC_W-1:0]   dac_code;
  logic               amp_enable;
  logic               busy_res;

  beep_scoreboard sb = new;
  int  cycles = 0;
  int  beats_sent = 0;
  int  starts_sent = 0;
  bit  hold_req = 1'b0;
  bit  fast_mode = 1'b0;

  swept_square_beep_generator #(
    .WARMUP_END(WARMUP_TICKS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .length_ms (length_ms),
    .start_hz  (start_hz),
    .sweep_step(sweep_step),
    .volume_pct(volume_pct),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dac_code  (dac_code),
    .amp_enable(amp_enable),
    .busy_res  (busy_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_beat(command, length_ms, start_hz, sweep_step, volume_pct);
      if (out_valid && out_ready)
        sb.check_result(dac_code, amp_enable, busy_res);
    end
  end

  // Output side: random back-pressure, steady ready in fast mode, plus one long hold on request.
  initial begin
    int r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (fast_mode) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Presents one beat and returns at the edge where it is taken; valid stays high.
  task send_beat(logic cmd, logic [15:0] len, logic [15:0] hz,
                 logic signed [15:0] sw, logic [9:0] vol);
    in_valid <= 1'b1;
    command <= cmd;
    length_ms <= len;
    start_hz <= hz;
    sweep_step <= sw;
    volume_pct <= vol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (cmd == CMD_START) starts_sent++;
  endtask

  task pause_sender();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (fast_mode) n = 0;
    else if (r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task start_beep(logic [15:0] len, logic [15:0] hz, logic signed [15:0] sw,
                  logic [9:0] vol);
    send_beat(CMD_START, len, hz, sw, vol);
    pause_sender();
  endtask

  // Ticks carry junk in the unused fields.
  task tick_beats(int n);
    for (int i = 0; i < n; i++) begin
      send_beat(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
      pause_sender();
    end
  endtask

  // one edge first so the last accepted beat is already in the queue
  task settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int len;
    int run;
    logic [15:0] hz;
    logic signed [15:0] sw;
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle ticks, clamp edges, zero length and zero frequency.
    send_beat(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 10'h3FF);
    send_beat(CMD_TICK, 16'h0000, 16'h0000, -16'sd32768, 10'h000);
    start_beep(16'd0, 16'd0, 16'sd0, 10'd0);
    tick_beats(WARMUP_TICKS + 1);
    start_beep(16'd2, 16'd65535, -16'sd32768, 10'd1023);
    tick_beats(WARMUP_TICKS + 10);
    // restart while busy, mid play and mid warm-up
    start_beep(16'd1, 16'd3000, 16'sd32767, 10'd5);
    tick_beats(50);
    start_beep(16'd65535, 16'd65535, 16'sd1, 10'd70);
    tick_beats(WARMUP_TICKS + 30);
    start_beep(16'd1, 16'd40000, 16'sd0, 10'd69);
    tick_beats(WARMUP_TICKS + 12);
    settle();

    // Block fills up behind a long output hold.
    fast_mode = 1'b1;
    hold_req = 1'b1;
    start_beep(16'd3, 16'd20000, 16'sd500, 10'd40);
    tick_beats(40);
    fast_mode = 1'b0;
    settle();

    while (beats_sent < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 4);
        else if (r < 95) len = $urandom_range(5, 20);
        else len = $urandom_range(0, 65535);
        r = $urandom_range(0, 99);
        if (r < 50) hz = 16'($urandom_range(1000, 65535));
        else if (r < 80) hz = 16'($urandom);
        else hz = 16'($urandom_range(0, 999));
        r = $urandom_range(0, 99);
        if (r < 40) sw = 16'($signed($urandom_range(0, 400)) - 200);
        else if (r < 80) sw = 16'($urandom);
        else sw = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sd32768;
        start_beep(16'(len), hz, sw, 10'($urandom));
        run = WARMUP_TICKS - 1 + len * 10 + $urandom_range(0, 3);
        if (run > 400) run = WARMUP_TICKS + $urandom_range(1, 200);
        // sometimes cut short so the next start lands on a busy beep
        if ($urandom_range(0, 4) == 0) run = $urandom_range(1, run);
        if (run > RANDOM_BEATS - beats_sent) run = RANDOM_BEATS - beats_sent;
        tick_beats(run);
      end else if (r < 93) begin
        tick_beats($urandom_range(1, 6));
      end else begin
        start_beep(16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
      end
    end
    settle();
    repeat (30) @(posedge clk);

    $display("Covered %0d beats (%0d beep starts), %0d results checked.",
             beats_sent, starts_sent, sb.checked);
    $display("Half-period clamped at the upper limit %0d times, at the lower %0d times.",
             sb.sat_hi, sb.sat_lo);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/ssbg_pkg.sv
design/ssbg_ctrl.sv
design/ssbg_datapath.sv
design/swept_square_beep_generator.sv
sim/testbench.sv
